/* src/anp_pkg.sv */
// Package for the ASCII number parser: parse phases, character codes and shared types.
// Depends on nothing; every other file of the parser uses it.
package anp_pkg;

    // Width of one character transaction and of one emitted value.
    localparam int CHAR_BITS = 8;
    localparam int OUT_BITS  = 32;

    typedef logic [CHAR_BITS-1:0]       t_char;
    typedef logic signed [OUT_BITS-1:0] t_value;

    // Characters that steer the parse.
    localparam t_char CH_MINUS  = 8'h2D;   // '-'
    localparam t_char CH_ZERO   = 8'h30;   // '0'
    localparam t_char CH_NINE   = 8'h39;   // '9'
    localparam t_char CH_X      = 8'h78;   // 'x'
    localparam t_char CH_UPPER_A = 8'h41;  // 'A'
    localparam t_char CH_UPPER_F = 8'h46;  // 'F'

    // Value of the letter 'A' as a hexadecimal digit.
    localparam logic [3:0] HEX_A_VALUE = 4'd10;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_MINUS = 3'd1,
        PH_ZERO  = 3'd2,
        PH_DEC   = 3'd3,
        PH_HEX   = 3'd4
    } t_phase;

    // Control result of one parse step.
    typedef struct packed {
        t_phase phase;
        logic   neg;
        logic   emit;
    } t_step_ctrl;

endpackage

/* src/anp_if.sv */
// Stream interfaces of the ASCII number parser: characters in, parsed values out.
// Depends on anp_pkg for the payload types.
interface anp_char_if;
    logic           valid;
    logic           ready;
    anp_pkg::t_char char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface anp_value_if;
    logic            valid;
    logic            ready;
    anp_pkg::t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* src/anp_step.sv */
// One parse step: next phase, sign flag and accumulator from one character.
// Depends on anp_pkg; combinational, used by ascii_number_parser.
module anp_step #(
    parameter int VALUE_BITS = 32
) (
    input  anp_pkg::t_char        i_char_code,
    input  anp_pkg::t_phase       i_phase,
    input  logic                  i_neg,
    input  logic [VALUE_BITS-1:0] i_acc,
    output anp_pkg::t_step_ctrl   o_ctrl,
    output logic [VALUE_BITS-1:0] o_acc,
    output anp_pkg::t_value       o_value
);
    import anp_pkg::*;

    logic                         is_dec;
    logic                         is_hex_letter;
    logic [3:0]                   digit;
    logic [VALUE_BITS-1:0]        digit_ext;
    logic [VALUE_BITS-1:0]        acc_x10;
    logic [VALUE_BITS-1:0]        acc_x16;
    logic [VALUE_BITS-1:0]        acc_end;
    logic signed [VALUE_BITS-1:0] signed_end;

    // Character classes and the digit value they carry.
    always_comb begin
        is_dec        = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        is_hex_letter = (i_char_code >= CH_UPPER_A) && (i_char_code <= CH_UPPER_F);
        if (is_hex_letter) begin
            digit = 4'(i_char_code - CH_UPPER_A) + HEX_A_VALUE;
        end else begin
            digit = 4'(i_char_code - CH_ZERO);
        end
        digit_ext = VALUE_BITS'(digit);
    end

    // Scaled accumulator: times ten as two shifts and an add, times sixteen as a shift.
    assign acc_x10 = (i_acc << 3) + (i_acc << 1);
    assign acc_x16 = i_acc << 4;

    // Phase transitions; anything not accepted ends the number.
    always_comb begin
        o_ctrl.phase = i_phase;
        o_ctrl.neg   = i_neg;
        o_ctrl.emit  = 1'b0;
        o_acc        = i_acc;
        case (i_phase)
            PH_MINUS: begin
                if (i_char_code == CH_ZERO) begin
                    o_acc        = '0;
                    o_ctrl.phase = PH_ZERO;
                end else if (is_dec) begin
                    o_acc        = digit_ext;
                    o_ctrl.phase = PH_DEC;
                end else begin
                    o_ctrl.emit = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_char_code == CH_X) begin
                    o_acc        = '0;
                    o_ctrl.phase = PH_HEX;
                end else if (is_dec) begin
                    o_acc        = digit_ext;
                    o_ctrl.phase = PH_DEC;
                end else begin
                    o_ctrl.emit = 1'b1;
                end
            end
            PH_DEC: begin
                if (is_dec) begin
                    o_acc = acc_x10 + digit_ext;
                end else begin
                    o_ctrl.emit = 1'b1;
                end
            end
            PH_HEX: begin
                if (is_dec || is_hex_letter) begin
                    o_acc = acc_x16 + digit_ext;
                end else begin
                    o_ctrl.emit = 1'b1;
                end
            end
            default: begin
                // The start phase, and unused codes that behave like it.
                if (i_char_code == CH_MINUS) begin
                    o_ctrl.neg   = 1'b1;
                    o_ctrl.phase = PH_MINUS;
                end else if (i_char_code == CH_ZERO) begin
                    o_acc        = '0;
                    o_ctrl.phase = PH_ZERO;
                end else if (is_dec) begin
                    o_acc        = digit_ext;
                    o_ctrl.phase = PH_DEC;
                end else begin
                    o_ctrl.emit = 1'b1;
                end
            end
        endcase

        // A finished number restarts the parse from a clean state.
        if (o_ctrl.emit) begin
            o_ctrl.phase = PH_START;
            o_ctrl.neg   = 1'b0;
            o_acc        = '0;
        end
    end

    // Final value: an empty number is zero, the sign is applied, then sign-extended or cut.
    always_comb begin
        if ((i_phase == PH_MINUS) || (i_phase == PH_ZERO) || (i_phase == PH_DEC)
                || (i_phase == PH_HEX)) begin
            acc_end = (i_phase == PH_MINUS) ? '0 : i_acc;
        end else begin
            acc_end = '0;
        end
        signed_end = i_neg ? signed'(-acc_end) : signed'(acc_end);
        o_value    = OUT_BITS'(signed_end);
    end

endmodule

/* src/ascii_number_parser.sv */
// Top level of the ASCII number parser: input register, parse step and result register.
// Depends on anp_pkg, anp_if.sv and anp_step.
//
//  Channel   Dir  Payload             Transaction
//  i_char    in   char_code [7:0]     one ASCII character
//  o_value   out  value [31:0] signed one parsed integer, when a number ends
//
// One character enters per cycle unless a waiting result stalls it.
// The rate is set by the single parse step between the input and result registers.
// Reset (synchronous, active low) empties both registers and returns to the start phase.
// A waiting result stalls only a character that ends another number; others pass.
module ascii_number_parser #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    anp_char_if.sink    i_char,
    anp_value_if.source o_value
);
    import anp_pkg::*;

    logic                  r_in_valid;
    t_char                 r_char;
    t_phase                r_phase;
    t_phase                n_phase;
    logic                  r_neg;
    logic                  n_neg;
    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] n_acc;
    logic                  r_out_valid;
    t_value                r_value;
    t_value                step_value;
    t_step_ctrl            step_ctrl;
    logic                  advance;

    // Parse step on the registered character.
    anp_step #(
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .i_char_code(r_char),
        .i_phase    (r_phase),
        .i_neg      (r_neg),
        .i_acc      (r_acc),
        .o_ctrl     (step_ctrl),
        .o_acc      (n_acc),
        .o_value    (step_value)
    );

    // The held character retires unless it has a result with nowhere to go.
    assign advance = r_in_valid && (!step_ctrl.emit || !r_out_valid || o_value.ready);
    assign i_char.ready = !r_in_valid || advance;
    assign n_phase = step_ctrl.phase;
    assign n_neg   = step_ctrl.neg;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_code;
        end
    end

    // Parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_value.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && step_ctrl.emit) begin
            r_value <= step_value;
        end
    end

    assign o_value.valid = r_out_valid;
    assign o_value.value = r_value;

endmodule

/* verif/ascii_number_parser_test.sv */
// Testbench for the ASCII number parser: streams characters through the block and checks
// every parsed value against a cycle-free model of the parse. Depends on anp_pkg, the
// stream interfaces in anp_if.sv and the ascii_number_parser top level.
module ascii_number_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import anp_pkg::*;

    // Run shape.
    localparam int RANDOM_CHARS = 1250;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_AT      = 400;
    localparam int CALM_FROM    = 600;
    localparam int CALM_TO      = 800;
    localparam int PAUSE_AT     = 950;

    // Characters used only by the stimulus.
    localparam t_char CH_SPACE   = 8'h20;
    localparam t_char CH_COMMA   = 8'h2C;
    localparam t_char CH_NEWLINE = 8'h0A;
    localparam t_char CH_NUL     = 8'h00;
    localparam t_char CH_ALL_SET = 8'hFF;
    localparam t_char CH_LOWER_A = 8'h61;
    localparam t_char CH_LOWER_G = 8'h67;
    localparam t_char CH_UPPER_Z = 8'h5A;

    // Tracks the parse state of the stream and holds the values still to come out.
    class anp_number_board;
        t_phase      phase;
        logic        negative;
        logic [31:0] acc;
        t_value      pending_values[$];
        int          errors;
        int          values_matched;
        int          negatives;
        int          hex_numbers;

        function new();
            phase          = PH_START;
            negative       = 1'b0;
            acc            = '0;
            errors         = 0;
            values_matched = 0;
            negatives      = 0;
            hex_numbers    = 0;
        endfunction

        // Advance the parse by one accepted character transaction.
        function void take_char(t_char c);
            logic        is_dec;
            logic        is_letter;
            logic        ends;
            logic [31:0] digit;
            t_value      result;
            is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
            is_letter = (c >= CH_UPPER_A) && (c <= CH_UPPER_F);
            digit     = is_letter ? 32'(c) - 32'(CH_UPPER_A) + 32'(HEX_A_VALUE)
                                  : 32'(c) - 32'(CH_ZERO);
            ends      = 1'b0;
            case (phase)
                PH_START, PH_MINUS: begin
                    if (phase == PH_START && c == CH_MINUS) begin
                        negative = 1'b1;
                        phase    = PH_MINUS;
                    end else if (c == CH_ZERO) begin
                        acc   = '0;
                        phase = PH_ZERO;
                    end else if (is_dec) begin
                        acc   = digit;
                        phase = PH_DEC;
                    end else begin
                        // Empty number: nothing was collected.
                        acc  = '0;
                        ends = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (c == CH_X) begin
                        acc   = '0;
                        phase = PH_HEX;
                    end else if (is_dec) begin
                        acc   = digit;
                        phase = PH_DEC;
                    end else begin
                        ends = 1'b1;
                    end
                end
                PH_DEC: begin
                    if (is_dec) acc = acc * 32'd10 + digit;
                    else ends = 1'b1;
                end
                default: begin
                    if (is_dec || is_letter) acc = acc * 32'd16 + digit;
                    else ends = 1'b1;
                end
            endcase

            // The ending character is consumed and the signed value is queued.
            if (ends) begin
                result = negative ? t_value'(-acc) : t_value'(acc);
                pending_values.push_back(result);
                if (negative) negatives++;
                if (phase == PH_HEX) hex_numbers++;
                phase    = PH_START;
                negative = 1'b0;
                acc      = '0;
            end
        endfunction

        // Compare one value transaction with the oldest pending value.
        function void match_value(t_value v);
            t_value want;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected value: expected none, actual %0d (0x%08h)",
                         $realtime, v, v);
                errors++;
            end else begin
                want = pending_values.pop_front();
                values_matched++;
                if (want !== v) begin
                    $display("%0t: value mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                             $realtime, want, want, v, v);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_values.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    anp_char_if  char_bus ();
    anp_value_if value_bus ();

    ascii_number_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_value (value_bus)
    );

    anp_number_board board = new();

    int chars_sent    = 0;
    int idle_cycles   = 0;
    int holds_done    = 0;
    int pauses_done   = 0;
    bit calm          = 1'b0;
    bit hold_request  = 1'b0;

    // Short directed stream: the byte extremes, an empty number, a second minus,
    // a leading zero that runs on into decimal, a lower-case hex letter, an empty
    // hex number, the most negative value and a lone zero.
    t_char directed_chars [28] = '{
        CH_ALL_SET,
        CH_MINUS, CH_MINUS,
        CH_ZERO, CH_ZERO + 8'd7, CH_NUL,
        CH_ZERO, CH_X, CH_UPPER_A, CH_UPPER_F, CH_LOWER_A,
        CH_ZERO, CH_X, CH_LOWER_G,
        CH_MINUS, CH_ZERO, CH_X, CH_ZERO + 8'd8, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO,
        CH_ZERO, CH_ZERO, CH_ZERO, CH_UPPER_Z,
        CH_ZERO, CH_SPACE
    };

    always #5 i_clk = ~i_clk;

    // Offer one character and wait for its transaction.
    task automatic send_char(input t_char c);
        while (!calm && $urandom_range(99) < 10) begin
            char_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        board.take_char(c);
        chars_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_char hex_char(input int unsigned v);
        return (v < 10) ? CH_ZERO + t_char'(v) : CH_UPPER_A + t_char'(v - 10);
    endfunction

    // One random number: mostly well formed, sometimes raw noise or a stray character.
    task automatic send_number();
        int unsigned kind;
        int unsigned count;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 4)) send_char(t_char'($urandom_range(255)));
        end else begin
            if ($urandom_range(2) == 0) send_char(CH_MINUS);
            if ($urandom_range(1)) begin
                send_char(CH_ZERO);
                send_char(CH_X);
                count = $urandom_range(0, 10);
                repeat (count) send_char(hex_char($urandom_range(15)));
            end else begin
                count = $urandom_range(1, 11);
                repeat (count) send_char(CH_ZERO + t_char'($urandom_range(9)));
            end
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(2))
                    0:       send_char(CH_MINUS);
                    1:       send_char(CH_X);
                    default: send_char(CH_LOWER_A + t_char'($urandom_range(5)));
                endcase
            end
            case ($urandom_range(3))
                0:       send_char(CH_SPACE);
                1:       send_char(CH_COMMA);
                2:       send_char(CH_NEWLINE);
                default: send_char(t_char'($urandom_range(255)));
            endcase
        end
    endtask

    // Character source: reset, directed stream, random stream, then drain.
    initial begin
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_chars[i]) send_char(directed_chars[i]);

        while (chars_sent < $size(directed_chars) + RANDOM_CHARS) begin
            calm = (chars_sent >= CALM_FROM) && (chars_sent < CALM_TO);
            if (chars_sent >= HOLD_AT && holds_done == 0 && !hold_request)
                hold_request = 1'b1;
            if (chars_sent >= PAUSE_AT && pauses_done == 0) begin
                // Let the block empty completely before going on.
                char_bus.valid <= 1'b0;
                while (board.pending() != 0) @(negedge i_clk);
                pauses_done++;
            end
            send_number();
        end
        calm = 1'b0;

        char_bus.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d characters and matched %0d values (%0d negative, %0d hexadecimal).",
                 chars_sent, board.values_matched, board.negatives, board.hex_numbers);
        $display("Output held off %0d time(s) for %0d cycles; input paused to drain %0d time(s).",
                 holds_done, HOLD_CYCLES, pauses_done);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Value sink: random back-pressure, plus one long hold-off on request.
    initial begin
        value_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                value_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                holds_done++;
            end
            value_bus.ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // Check every value transaction at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && value_bus.valid && value_bus.ready)
            board.match_value(value_bus.value);
    end

    // Watchdog: ends the run when no transaction happens for too long.
    always @(posedge i_clk) begin
        if ((char_bus.valid && char_bus.ready) || (value_bus.valid && value_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d values still pending",
                         $realtime, IDLE_LIMIT, board.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
